// ===== rtl/fcc_pkg.sv =====
// ============================================================================
// fcc_pkg
// Shared constants, types and helpers for the clamped FIR convolution block.
// ============================================================================
package fcc_pkg;

    // Filter size and tree shape
    localparam int MAX_TAPS = 32;
    localparam int LEVELS   = $clog2(MAX_TAPS);
    localparam int TREE_N   = 1 << LEVELS;

    // Field widths
    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 5;
    localparam int CFG_W  = 6;
    localparam int DATA_W = 40;

    // Arithmetic widths
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int SUM_W   = PROD_W + LEVELS;
    localparam int FRAC_SH = 14;
    localparam int Q_W     = SUM_W - FRAC_SH;

    // Counter widths: tap count up to MAX_TAPS, tail count up to MAX_TAPS-1
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int FL_W  = $clog2(MAX_TAPS);

    localparam logic [CFG_W-1:0]        TAP_COUNT_RST = 6'd32;
    localparam logic signed [SMP_W-1:0] OUT_HI        = 16'sd20480;
    localparam logic signed [SMP_W-1:0] OUT_LO        = -16'sd20480;

    typedef enum logic {
        CMD_TAP    = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // Per-cycle strobes broadcast along the cell row
    typedef struct packed {
        logic shift;   // move history one cell down the row
        logic cap;     // register coefficient * history product
    } t_cell_ctl;

    // Taps in use: zero acts as one, oversize saturates
    function automatic logic [CNT_W-1:0] taps_in_use(input logic [CFG_W-1:0] tc);
        logic [CNT_W-1:0] n;
        if (tc == '0) begin
            n = CNT_W'(1);
        end else if (int'(tc) > MAX_TAPS) begin
            n = CNT_W'(MAX_TAPS);
        end else begin
            n = CNT_W'(tc);
        end
        return n;
    endfunction

endpackage

// ===== rtl/fcc_cell.sv =====
// ============================================================================
// fcc_cell
// One tap cell: holds a coefficient and one history word, hands the word on
// to its neighbor and registers its own product.
// ============================================================================
module fcc_cell
    import fcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [SMP_W-1:0]   i_hist,
    input  logic                      i_tap_en,
    input  logic                      i_coef_we,
    input  logic signed [COEF_W-1:0]  i_coef,
    output logic signed [SMP_W-1:0]   o_hist,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [COEF_W-1:0] r_coef;
    logic signed [SMP_W-1:0]  r_hist;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    // History word, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= i_hist;
        end
    end

    // Coefficient, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef <= i_coef;
        end
    end

    // Product, gated off for taps beyond the count in use
    always_comb begin
        n_prod = r_coef * r_hist;
        if (!i_tap_en) begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_prod <= n_prod;
        end
    end

    assign o_hist = r_hist;
    assign o_prod = r_prod;

endmodule

// ===== rtl/fcc_sum_tree.sv =====
// ============================================================================
// fcc_sum_tree
// Registered pairwise adder tree over the cell products, one level per
// stage, with per-level valid and a ready chain for back pressure.
// ============================================================================
module fcc_sum_tree
    import fcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_last,
    input  logic signed [PROD_W-1:0]  i_prod [TREE_N],
    output logic                      o_ready,
    output logic                      o_valid,
    output logic                      o_last,
    output logic signed [SUM_W-1:0]   o_sum,
    input  logic                      i_ready
);

    logic signed [SUM_W-1:0] w_lvl0 [TREE_N];
    logic signed [SUM_W-1:0] r_sum  [1:LEVELS][TREE_N/2];
    logic [LEVELS:1]         r_vld;
    logic [LEVELS:1]         r_lst;
    logic [LEVELS:0]         w_vld;
    logic [LEVELS:0]         w_lst;
    logic [LEVELS+1:1]       w_rdy;

    // Sign-extend leaves
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            w_lvl0[i] = SUM_W'(i_prod[i]);
        end
    end

    // Valid, last and ready per level
    always_comb begin
        w_vld[0]          = i_valid;
        w_lst[0]          = i_last;
        w_rdy[LEVELS + 1] = i_ready;
        for (int k = 1; k <= LEVELS; k++) begin
            w_vld[k] = r_vld[k];
            w_lst[k] = r_lst[k];
        end
        for (int k = LEVELS; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k + 1];
        end
    end

    for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_vld[k - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_vld[k - 1]) begin
                r_lst[k] <= w_lst[k - 1];
            end
        end

        for (genvar i = 0; i < (TREE_N >> k); i++) begin : g_node
            if (k == 1) begin : g_leaf
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k] && w_vld[k - 1]) begin
                        r_sum[k][i] <= w_lvl0[2*i] + w_lvl0[2*i + 1];
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k] && w_vld[k - 1]) begin
                        r_sum[k][i] <= r_sum[k - 1][2*i] + r_sum[k - 1][2*i + 1];
                    end
                end
            end
        end
    end

    assign o_ready = w_rdy[1];
    assign o_valid = r_vld[LEVELS];
    assign o_last  = r_lst[LEVELS];
    assign o_sum   = r_sum[LEVELS][0];

endmodule

// ===== rtl/fir_convolution_clamped.sv =====
// ============================================================================
// fir_convolution_clamped
// Direct-form FIR over sample blocks with tail flush and +/-10 V clamp.
// ============================================================================
//  channel   | direction | contents
//  s_axis    | in        | tuser = cmd; tdata = tap_index, tap_value, sample
//            |           | (lowest bits first); tlast = last
//  m_axis    | out       | tdata = filtered_sample; tlast = last_out
//  cfg       | in        | write enable + 6-bit tap_count
//
// One word per cycle in and out unless m_axis stalls or a tail flush holds
// the input. An accepted sample passes history shift, product, LEVELS adder
// levels and clamp register. A last sample is followed by taps-in-use minus
// one tail words generated internally; the input is held off meanwhile. A
// tap load is taken only once the preceding sample has been multiplied.
// Reset is synchronous, active low, and zeroes the history; coefficients
// are undefined until loaded. Stalls on m_axis ripple back stage by stage.
// ============================================================================
module fir_convolution_clamped
    import fcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // stream in
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [DATA_W-1:0]   i_s_axis_tdata,   // [4:0] tap_index, [20:5] tap_value,
                                                  // [36:21] sample, [39:37] zero
    input  logic                i_s_axis_tuser,   // [0] cmd
    input  logic                i_s_axis_tlast,
    // stream out
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [SMP_W-1:0]    o_m_axis_tdata,   // [15:0] filtered_sample
    output logic                o_m_axis_tlast,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    // Input field unpack
    t_cmd                     w_cmd;
    logic [IDX_W-1:0]         w_idx;
    logic signed [COEF_W-1:0] w_tapv;
    logic signed [SMP_W-1:0]  w_smp;

    assign w_cmd  = t_cmd'(i_s_axis_tuser);
    assign w_idx  = i_s_axis_tdata[IDX_W-1:0];
    assign w_tapv = i_s_axis_tdata[IDX_W+COEF_W-1:IDX_W];
    assign w_smp  = i_s_axis_tdata[IDX_W+COEF_W+SMP_W-1:IDX_W+COEF_W];

    logic [CFG_W-1:0]         r_tap_count;
    logic [FL_W-1:0]          r_flush;
    logic                     r_clear;
    logic                     r_s_vld;
    logic                     r_s_lst;
    logic                     r_p_vld;
    logic                     r_p_lst;
    logic                     r_o_vld;
    logic                     r_o_lst;
    logic signed [SMP_W-1:0]  r_o_data;
    logic signed [SMP_W-1:0]  n_o_data;

    logic [CNT_W-1:0]         w_n;
    logic                     w_rdy_o;
    logic                     w_rdy_p;
    logic                     w_rdy_s;
    logic                     w_tree_rdy;
    logic                     w_acc;
    logic                     w_smp_acc;
    logic                     w_tap_acc;
    logic                     w_inject;
    logic                     w_shift;
    logic                     w_shift_lst;
    logic                     w_cap;
    logic signed [SMP_W-1:0]  w_x;
    t_cell_ctl                w_ctl;

    logic signed [SMP_W-1:0]  w_hist_in [MAX_TAPS];
    logic signed [SMP_W-1:0]  w_hist    [MAX_TAPS];
    logic signed [PROD_W-1:0] w_prod    [TREE_N];

    logic                     w_tree_vld;
    logic                     w_tree_lst;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [Q_W-1:0]    w_q;

    assign w_n = taps_in_use(r_tap_count);

    // Ready chain, output side first
    assign w_rdy_o = !r_o_vld || i_m_axis_tready;
    assign w_rdy_p = !r_p_vld || w_tree_rdy;
    assign w_rdy_s = !r_s_vld || w_rdy_p;

    assign o_s_axis_tready = w_rdy_s && (r_flush == '0);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_smp_acc       = w_acc && (w_cmd == CMD_SAMPLE);
    assign w_tap_acc       = w_acc && (w_cmd == CMD_TAP);

    // Tail words shift zeros in
    assign w_inject    = (r_flush != '0) && w_rdy_s;
    assign w_shift     = w_smp_acc || w_inject;
    assign w_shift_lst = w_inject ? (r_flush == FL_W'(1))
                                  : (i_s_axis_tlast && (w_n == CNT_W'(1)));
    assign w_x         = w_inject ? '0 : w_smp;
    assign w_cap       = r_s_vld && w_rdy_p;

    assign w_ctl.shift = w_shift;
    assign w_ctl.cap   = w_cap;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    // Tail counter and end-of-block clear flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= '0;
            r_clear <= 1'b0;
        end else begin
            if (w_smp_acc && i_s_axis_tlast && (w_n != CNT_W'(1))) begin
                r_flush <= FL_W'(w_n - CNT_W'(1));
            end else if (w_inject) begin
                r_flush <= r_flush - FL_W'(1);
            end
            if (w_shift) begin
                r_clear <= w_shift_lst;
            end
        end
    end

    // History stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_shift) begin
            r_s_vld <= 1'b1;
        end else if (w_cap) begin
            r_s_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_s_lst <= w_shift_lst;
        end
    end

    // Product stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_rdy_p) begin
            r_p_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_p_lst <= r_s_lst;
        end
    end

    // Cell row; history past a finished block is zeroed on the next shift
    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_hist_in[j] = w_x;
        end else begin : g_body
            assign w_hist_in[j] = r_clear ? '0 : w_hist[j - 1];
        end

        fcc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_hist    (w_hist_in[j]),
            .i_tap_en  (int'(w_n) > j),
            .i_coef_we (w_tap_acc && (int'(w_idx) == j)),
            .i_coef    (w_tapv),
            .o_hist    (w_hist[j]),
            .o_prod    (w_prod[j])
        );
    end

    for (genvar j = MAX_TAPS; j < TREE_N; j++) begin : g_pad
        assign w_prod[j] = '0;
    end

    fcc_sum_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .i_last  (r_p_lst),
        .i_prod  (w_prod),
        .o_ready (w_tree_rdy),
        .o_valid (w_tree_vld),
        .o_last  (w_tree_lst),
        .o_sum   (w_sum),
        .i_ready (w_rdy_o)
    );

    // Floor by 2^14 then clamp to +/-10 V
    assign w_q = Q_W'(w_sum >>> FRAC_SH);

    always_comb begin
        if (w_q > Q_W'(OUT_HI)) begin
            n_o_data = OUT_HI;
        end else if (w_q < Q_W'(OUT_LO)) begin
            n_o_data = OUT_LO;
        end else begin
            n_o_data = SMP_W'(w_q);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_rdy_o) begin
            r_o_vld <= w_tree_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o && w_tree_vld) begin
            r_o_data <= n_o_data;
            r_o_lst  <= w_tree_lst;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_lst;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != '0) |-> !o_s_axis_tready)
        else $error("input accepted during tail flush");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata) <= OUT_HI &&
                             $signed(o_m_axis_tdata) >= OUT_LO))
        else $error("output word outside clamp range");

    a_tap_after_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tap_acc |-> (!r_s_vld || w_rdy_p))
        else $error("tap load overtook a pending product");

    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_smp_acc && i_s_axis_tlast && (w_n != CNT_W'(1)))
            |=> (r_flush == FL_W'($past(w_n) - CNT_W'(1))))
        else $error("tail count not loaded from tap count");

endmodule
